FILE: rtl/core/asgr_pkg.sv
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types and constants for the SGR escape sequence parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

   localparam int MAX_SEQ_LEN_DEF = 255;

   // number parse phases
   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_STOP   = 2'd2;

   // bytes of interest
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_M        = 8'h6D;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   // SGR codes
   localparam logic [7:0] SGR_RESET    = 8'd0;
   localparam logic [7:0] SGR_BOLD     = 8'd1;
   localparam logic [7:0] SGR_NORMAL   = 8'd22;
   localparam logic [7:0] SGR_FG_FIRST = 8'd30;
   localparam logic [7:0] SGR_FG_LAST  = 8'd37;
   localparam logic [7:0] SGR_BG_FIRST = 8'd40;
   localparam logic [7:0] SGR_BG_LAST6 = 8'd46;
   localparam logic [7:0] SGR_BG_WHITE = 8'd47;

   // palette indices
   localparam logic [3:0] PAL_BLACK = 4'd0;
   localparam logic [3:0] PAL_LGRAY = 4'd7;
   localparam logic [3:0] PAL_WHITE = 4'd8;

   localparam logic [7:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic       seen_bracket;
      logic [1:0] phase;
      logic       negative;
      logic [7:0] magnitude;
   } seq_type;

   typedef struct packed {
      logic [3:0] fg;
      logic [3:0] bg;
      logic       bold;
   } attr_type;

   localparam seq_type SEQ_CLEAR = '{seen_bracket: 1'b0, phase: PH_SKIP,
                                     negative: 1'b0, magnitude: 8'd0};
   localparam attr_type ATTR_DEFAULT = '{fg: PAL_LGRAY, bg: PAL_BLACK, bold: 1'b0};

endpackage

FILE: rtl/core/asgr_step.sv
// ----------------------------------------------------------------------------
// asgr_step
// Next-state logic for one byte: bracket detect, atoi-style number parse,
// SGR code decode and overlong sequence abandon.
// ----------------------------------------------------------------------------
module asgr_step #(
   parameter int MAX_SEQ_LEN = asgr_pkg::MAX_SEQ_LEN_DEF,
   localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1)
) (
   input  logic [7:0]         ch,
   input  asgr_pkg::seq_type  seq_cur,
   input  logic [CNT_W-1:0]   cnt_cur,
   input  asgr_pkg::attr_type attr_cur,
   output asgr_pkg::seq_type  seq_nxt,
   output logic [CNT_W-1:0]   cnt_nxt,
   output asgr_pkg::attr_type attr_nxt,
   output logic               done
);

   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SEQ_LEN);

   logic        is_blank;
   logic        is_sign;
   logic        is_digit;
   logic [11:0] mag_times10;
   logic [7:0]  mag_digit;
   logic [CNT_W-1:0] cnt_inc;

   assign is_blank = (ch == asgr_pkg::CH_SPACE) ||
                     (ch >= asgr_pkg::CH_TAB && ch <= asgr_pkg::CH_CR);
   assign is_sign  = (ch == asgr_pkg::CH_MINUS) || (ch == asgr_pkg::CH_PLUS);
   assign is_digit = (ch >= asgr_pkg::CH_ZERO) && (ch <= asgr_pkg::CH_NINE);

   // mag * 10 + digit, saturate at 255
   assign mag_times10 = {1'b0, seq_cur.magnitude, 3'b000}
                      + {3'b000, seq_cur.magnitude, 1'b0}
                      + {8'd0, 4'(ch - asgr_pkg::CH_ZERO)};
   assign mag_digit   = (mag_times10 > 12'(asgr_pkg::MAG_MAX)) ? asgr_pkg::MAG_MAX
                                                               : mag_times10[7:0];

   // count never sits at the limit between bytes, so the increment cannot wrap
   assign cnt_inc = cnt_cur + CNT_W'(1);

   always_comb begin
      seq_nxt  = seq_cur;
      attr_nxt = attr_cur;
      done     = 1'b0;
      cnt_nxt  = cnt_inc;

      if (!seq_cur.seen_bracket) begin
         if (ch == asgr_pkg::CH_LBRACKET) begin
            seq_nxt.seen_bracket = 1'b1;
         end
      end else if (ch == asgr_pkg::CH_M) begin
         done = 1'b1;
         if (seq_cur.magnitude == asgr_pkg::SGR_RESET) begin
            attr_nxt = asgr_pkg::ATTR_DEFAULT;
         end else if (!seq_cur.negative) begin
            case (seq_cur.magnitude) inside
               asgr_pkg::SGR_BOLD: begin
                  attr_nxt.bold = 1'b1;
               end
               asgr_pkg::SGR_NORMAL: begin
                  attr_nxt.bold = 1'b0;
               end
               [asgr_pkg::SGR_FG_FIRST:asgr_pkg::SGR_FG_LAST]: begin
                  attr_nxt.fg = 4'(seq_cur.magnitude - asgr_pkg::SGR_FG_FIRST);
               end
               [asgr_pkg::SGR_BG_FIRST:asgr_pkg::SGR_BG_LAST6]: begin
                  attr_nxt.bg = 4'(seq_cur.magnitude - asgr_pkg::SGR_BG_FIRST);
               end
               asgr_pkg::SGR_BG_WHITE: begin
                  attr_nxt.bg = asgr_pkg::PAL_WHITE;
               end
               default: begin
               end
            endcase
         end
      end else begin
         case (seq_cur.phase)
            asgr_pkg::PH_SKIP: begin
               if (is_sign) begin
                  seq_nxt.negative = (ch == asgr_pkg::CH_MINUS);
                  seq_nxt.phase    = asgr_pkg::PH_DIGITS;
               end else if (!is_blank) begin
                  // first non-blank, non-sign byte is parsed as a digit position
                  if (is_digit) begin
                     seq_nxt.phase     = asgr_pkg::PH_DIGITS;
                     seq_nxt.magnitude = mag_digit;
                  end else begin
                     seq_nxt.phase = asgr_pkg::PH_STOP;
                  end
               end
            end
            asgr_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  seq_nxt.magnitude = mag_digit;
               end else begin
                  seq_nxt.phase = asgr_pkg::PH_STOP;
               end
            end
            default: begin
            end
         endcase
      end

      // drop the sequence on completion or when it runs too long
      if (done || (cnt_inc == CNT_LIMIT)) begin
         seq_nxt = asgr_pkg::SEQ_CLEAR;
         cnt_nxt = '0;
      end
   end

endmodule

FILE: rtl/core/ansi_sgr_color_parser_core.sv
// An accepted request word is held in the input register, its response word in
// the response register. Throughput: one word per cycle while rsp_stall is low;
// the single-pass step logic between the two registers sets this figure.
// Reset: synchronous, active high; clears both stages, the parse state and
// the attributes (foreground light gray, background black, bold off).
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_core
// SGR escape sequence parser: one byte in, current attributes out per word.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_core #(
   parameter int MAX_SEQ_LEN = asgr_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_done_res,
   output logic [3:0] rsp_fg_index,
   output logic [3:0] rsp_bg_index,
   output logic       rsp_bold
);

   localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_ch_ff, in_ch_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_done_ff, out_done_in;
   asgr_pkg::attr_type out_attr_ff, out_attr_in;
   asgr_pkg::seq_type  seq_ff, seq_in;
   asgr_pkg::attr_type attr_ff, attr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   asgr_pkg::seq_type  step_seq;
   asgr_pkg::attr_type step_attr;
   logic [CNT_W-1:0]   step_cnt;
   logic               step_done;

   logic out_free;
   logic advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   asgr_step #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_step (
      .ch       (in_ch_ff),
      .seq_cur  (seq_ff),
      .cnt_cur  (cnt_ff),
      .attr_cur (attr_ff),
      .seq_nxt  (step_seq),
      .cnt_nxt  (step_cnt),
      .attr_nxt (step_attr),
      .done     (step_done)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_ch_in     = in_ch_ff;
      out_valid_in = out_valid_ff;
      out_done_in  = out_done_ff;
      out_attr_in  = out_attr_ff;
      seq_in       = seq_ff;
      attr_in      = attr_ff;
      cnt_in       = cnt_ff;

      if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         // commit the step and load the response word
         seq_in       = step_seq;
         attr_in      = step_attr;
         cnt_in       = step_cnt;
         out_valid_in = 1'b1;
         out_done_in  = step_done;
         out_attr_in  = step_attr;
         in_valid_in  = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seq_ff       <= asgr_pkg::SEQ_CLEAR;
         attr_ff      <= asgr_pkg::ATTR_DEFAULT;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seq_ff       <= seq_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff    <= in_ch_in;
      out_done_ff <= out_done_in;
      out_attr_ff <= out_attr_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_done_res = out_done_ff;
   assign rsp_fg_index = out_attr_ff.fg;
   assign rsp_bg_index = out_attr_ff.bg;
   assign rsp_bold     = out_attr_ff.bold;

   // number state stays clear until a bracket opens the code
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !seq_ff.seen_bracket |-> (seq_ff.magnitude == 8'd0 && !seq_ff.negative &&
                                seq_ff.phase == asgr_pkg::PH_SKIP))
      else $error("parse state set before bracket");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(MAX_SEQ_LEN))
      else $error("byte count reached the limit between words");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && step_done) |=> (!seq_ff.seen_bracket && cnt_ff == '0 &&
                                  rsp_done_res))
      else $error("completed sequence not cleared");

   a_palette_range: assert property (@(posedge clock) disable iff (reset)
      attr_ff.fg <= asgr_pkg::PAL_LGRAY && attr_ff.bg <= asgr_pkg::PAL_WHITE)
      else $error("attribute outside palette");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(out_attr_ff) &&
                                    $stable(out_done_ff)))
      else $error("stalled response word changed");

endmodule
